FILE: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is held.
`define A_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, skipped while reset is held.
`define A_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also covers reset cycles.
`define A_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/gbnsw_pkg.sv
// Package: types and constants of the Go-Back-N sender window block.
`timescale 1ns / 1ps

package gbnsw_pkg;

    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 16;
    localparam int TAG_W    = 16;
    localparam int OSEQ_W   = 8;
    localparam int OFLT_W   = 5;
    localparam int LIMREG_W = 5;
    localparam int TIMER_W  = 16;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_WINDOW_LIMIT  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [LIMREG_W-1:0] WINDOW_LIMIT_RST  = 5'd16;
    localparam logic [TIMER_W-1:0]  TIMEOUT_TICKS_RST = 16'd100;

    typedef struct packed {
        logic [OFLT_W-1:0] in_flight;
        logic              dup_ack;
        logic              accepted;
        logic              last;
        logic              is_resend;
        logic [TAG_W-1:0]  tx_tag;
        logic [OSEQ_W-1:0] tx_seq;
        logic              tx_valid;
    } t_result;

    typedef struct packed {
        logic item_go;
        logic walk_start;
        logic walk_read;
        logic walk_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_needed;
        logic walk_last;
    } t_dp_status;

endpackage

FILE: design/gbnsw_ctrl.sv
// Controller: item acceptance and the sequencer of the timeout resend walk.
`timescale 1ns / 1ps

module gbnsw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_q_full,
    input  gbnsw_pkg::t_dp_status i_status,
    output logic                  o_in_ready,
    output gbnsw_pkg::t_dp_cmd    o_cmd
);
    import gbnsw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready       = !i_q_full;
                o_cmd.item_go    = i_in_valid && !i_q_full;
                o_cmd.walk_start = o_cmd.item_go && i_status.walk_needed;
                if (o_cmd.walk_start) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.walk_read = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (!i_q_full) begin
                    o_cmd.walk_emit = 1'b1;
                    o_cmd.walk_read = !i_status.walk_last;
                    if (i_status.walk_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/gbnsw_dpath.sv
// Datapath: window state, timer, configuration registers and slot tag memory.
`timescale 1ns / 1ps

module gbnsw_dpath #(
    parameter int WINDOW_DEPTH = 16,
    parameter int SEQ_SPACE    = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gbnsw_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [gbnsw_pkg::CFG_DW-1:0]    i_cfg_wdata,
    input  logic [1:0]                      i_item_cmd,
    input  logic [gbnsw_pkg::TAG_W-1:0]     i_item_tag,
    input  logic [gbnsw_pkg::OSEQ_W-1:0]    i_item_ack_seq,
    input  logic                            i_item_corrupt,
    input  gbnsw_pkg::t_dp_cmd              i_cmd,
    output gbnsw_pkg::t_dp_status           o_status,
    output logic                            o_push,
    output gbnsw_pkg::t_result              o_result
);
    import gbnsw_pkg::*;

    localparam int SEQ_W  = $clog2(SEQ_SPACE);
    localparam int OCC_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int MAXW   = (WINDOW_DEPTH < SEQ_SPACE - 1) ? WINDOW_DEPTH : SEQ_SPACE - 1;
    localparam int LIM_W  = (OCC_W > LIMREG_W) ? OCC_W : LIMREG_W;
    localparam int ACK_N  = 1 << OSEQ_W;

    localparam logic [SEQ_W-1:0]  SEQ_LAST  = SEQ_W'(SEQ_SPACE - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

    logic [LIMREG_W-1:0] r_win_lim;
    logic [TIMER_W-1:0]  r_timeout;
    logic [SEQ_W-1:0]    r_base, n_base;
    logic [SEQ_W-1:0]    r_next, n_next;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [TIMER_W-1:0]  r_timer, n_timer;
    logic                r_run, n_run;
    logic [OCC_W-1:0]    r_w_idx, n_w_idx;
    logic [SLOT_W-1:0]   r_w_slot, n_w_slot;
    logic [SEQ_W-1:0]    r_w_seq, n_w_seq;
    logic [TAG_W-1:0]    r_slot_tags [WINDOW_DEPTH];
    logic [TAG_W-1:0]    r_rd_tag;

    logic [SEQ_W-1:0]    ack_mod_tbl [ACK_N];
    logic [SEQ_W-1:0]    ack_mod;
    logic [LIM_W-1:0]    lim;
    logic                full;
    logic [OCC_W:0]      wr_sum;
    logic [SLOT_W-1:0]   wr_addr;
    logic                mem_we;
    logic                rd_en;
    logic [TIMER_W-1:0]  cnt_inc;
    logic [TIMER_W-1:0]  tmo_lim;
    logic                tmo_hit;
    logic                walk_last;
    logic [SEQ_W-1:0]    sel_seq;
    logic [SEQ_W+OSEQ_W-1:0] seq_ext;
    logic [OCC_W+OFLT_W-1:0] occ_ext;

    for (genvar g = 0; g < ACK_N; g++) begin : g_ack_mod
        localparam int unsigned MODV = g % SEQ_SPACE;
        assign ack_mod_tbl[g] = SEQ_W'(MODV);
    end

    assign ack_mod = ack_mod_tbl[i_item_ack_seq];

    always_comb begin
        lim = LIM_W'(r_win_lim);
        if (lim == '0) begin
            lim = LIM_W'(1);
        end else if (lim > LIM_W'(MAXW)) begin
            lim = LIM_W'(MAXW);
        end
        full = LIM_W'(r_occ) >= lim;

        wr_sum = (OCC_W+1)'(r_head) + (OCC_W+1)'(r_occ);
        if (wr_sum >= (OCC_W+1)'(WINDOW_DEPTH)) begin
            wr_sum = wr_sum - (OCC_W+1)'(WINDOW_DEPTH);
        end
        wr_addr = SLOT_W'(wr_sum);

        cnt_inc = (r_timer != '1) ? r_timer + TIMER_W'(1) : r_timer;
        tmo_lim = (r_timeout == '0) ? TIMER_W'(1) : r_timeout;
        tmo_hit = cnt_inc >= tmo_lim;

        walk_last = (r_w_idx + OCC_W'(1)) == r_occ;
    end

    assign o_status.walk_needed = (i_item_cmd == CMD_TICK) && r_run && tmo_hit
                                  && (r_occ != '0);
    assign o_status.walk_last   = walk_last;

    always_comb begin
        n_base   = r_base;
        n_next   = r_next;
        n_occ    = r_occ;
        n_head   = r_head;
        n_timer  = r_timer;
        n_run    = r_run;
        n_w_idx  = r_w_idx;
        n_w_slot = r_w_slot;
        n_w_seq  = r_w_seq;
        mem_we   = 1'b0;
        rd_en    = 1'b0;
        o_push   = 1'b0;
        o_result = '0;
        sel_seq  = '0;

        if (i_cmd.item_go) begin
            o_result.last = 1'b1;
            o_push        = !o_status.walk_needed;
            unique case (i_item_cmd)
                CMD_SEND: begin
                    if (!full) begin
                        mem_we = 1'b1;
                        if (r_occ == '0) begin
                            n_timer = '0;
                            n_run   = 1'b1;
                        end
                        n_next = (r_next == SEQ_LAST) ? '0 : r_next + SEQ_W'(1);
                        n_occ  = r_occ + OCC_W'(1);
                        o_result.tx_valid = 1'b1;
                        o_result.tx_tag   = i_item_tag;
                        o_result.accepted = 1'b1;
                        sel_seq           = r_next;
                    end
                end
                CMD_ACK: begin
                    if (!i_item_corrupt && r_occ != '0) begin
                        if (ack_mod == r_base) begin
                            n_base = (r_base == SEQ_LAST) ? '0 : r_base + SEQ_W'(1);
                            n_head = (r_head == SLOT_LAST) ? '0 : r_head + SLOT_W'(1);
                            n_occ  = r_occ - OCC_W'(1);
                        end else begin
                            o_result.dup_ack = 1'b1;
                        end
                        n_timer = '0;
                        n_run   = n_occ != '0;
                    end
                end
                CMD_TICK: begin
                    if (r_run) begin
                        n_timer = tmo_hit ? '0 : cnt_inc;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.walk_start) begin
            n_w_idx  = '0;
            n_w_slot = r_head;
            n_w_seq  = r_base;
        end

        if (i_cmd.walk_read) begin
            rd_en    = 1'b1;
            n_w_slot = (r_w_slot == SLOT_LAST) ? '0 : r_w_slot + SLOT_W'(1);
        end

        if (i_cmd.walk_emit) begin
            o_push             = 1'b1;
            o_result.tx_valid  = 1'b1;
            o_result.tx_tag    = r_rd_tag;
            o_result.is_resend = 1'b1;
            o_result.last      = walk_last;
            sel_seq            = r_w_seq;
            n_w_idx            = r_w_idx + OCC_W'(1);
            n_w_seq            = (r_w_seq == SEQ_LAST) ? '0 : r_w_seq + SEQ_W'(1);
        end

        seq_ext            = {{OSEQ_W{1'b0}}, sel_seq};
        occ_ext            = {{OFLT_W{1'b0}}, n_occ};
        o_result.tx_seq    = seq_ext[OSEQ_W-1:0];
        o_result.in_flight = occ_ext[OFLT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_lim <= WINDOW_LIMIT_RST;
            r_timeout <= TIMEOUT_TICKS_RST;
            r_base    <= '0;
            r_next    <= '0;
            r_occ     <= '0;
            r_head    <= '0;
            r_timer   <= '0;
            r_run     <= 1'b0;
            r_w_idx   <= '0;
            r_w_slot  <= '0;
            r_w_seq   <= '0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_WINDOW_LIMIT) begin
                r_win_lim <= i_cfg_wdata[LIMREG_W-1:0];
            end
            if (i_cfg_we && i_cfg_addr == CFG_TIMEOUT_TICKS) begin
                r_timeout <= i_cfg_wdata[TIMER_W-1:0];
            end
            r_base   <= n_base;
            r_next   <= n_next;
            r_occ    <= n_occ;
            r_head   <= n_head;
            r_timer  <= n_timer;
            r_run    <= n_run;
            r_w_idx  <= n_w_idx;
            r_w_slot <= n_w_slot;
            r_w_seq  <= n_w_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_tags[wr_addr] <= i_item_tag;
        end
        if (rd_en) begin
            r_rd_tag <= r_slot_tags[r_w_slot];
        end
    end

endmodule

FILE: design/gbnsw_outq.sv
// Output queue: two-entry result buffer in front of the master stream.
`timescale 1ns / 1ps

module gbnsw_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gbnsw_pkg::t_result i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output gbnsw_pkg::t_result o_data,
    output logic               o_full
);
    import gbnsw_pkg::*;

    t_result    r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_data  = r_q[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: design/gbn_sender_window_top.sv
// Top level: Go-Back-N sender window control with stream ports.
//
//   port group   dir   role
//   s_axis_*     in    send requests, acknowledgements, timer ticks
//   m_axis_*     out   transmit / status results, tlast on the final one
//   i_cfg_*      in    window_limit (index 0), timeout_ticks (index 1)
//
// Send, acknowledgement and tick transfers are taken while the output queue is not full.
// A timeout resend holds s_axis_tready low: S_FETCH reads the oldest tag,
// then S_EMIT sends one packet per cycle, while the output queue has room,
// from the single read port of the slot tag memory.
// A two-entry output queue lets a new transfer in while a result waits.
// Reset is synchronous, active low; the slot tag memory is not cleared.
`timescale 1ns / 1ps

module gbn_sender_window_top #(
    parameter int WINDOW_DEPTH = 16,
    parameter int SEQ_SPACE    = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gbnsw_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [gbnsw_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,  // payload_tag[15:0], ack_seq[23:16]
    input  logic [2:0]                   s_axis_tuser,  // cmd[1:0], ack_corrupt[2]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata,  // tx_seq[7:0], tx_tag[23:8],
                                                        // in_flight[28:24], zero[31:29]
    output logic [3:0]                   m_axis_tuser,  // tx_valid, is_resend, accepted,
                                                        // dup_ack
    output logic                         m_axis_tlast
);
    import gbnsw_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_result    push_data;
    t_result    q_data;
    logic       push;
    logic       q_full;

    gbnsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_q_full   (q_full),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    gbnsw_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SEQ_SPACE    (SEQ_SPACE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_item_cmd     (s_axis_tuser[1:0]),
        .i_item_tag     (s_axis_tdata[15:0]),
        .i_item_ack_seq (s_axis_tdata[23:16]),
        .i_item_corrupt (s_axis_tuser[2]),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_push         (push),
        .o_result       (push_data)
    );

    gbnsw_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (m_axis_tvalid && m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data),
        .o_full  (q_full)
    );

    assign m_axis_tdata = {3'b000, q_data.in_flight, q_data.tx_tag, q_data.tx_seq};
    assign m_axis_tuser = {q_data.dup_ack, q_data.accepted, q_data.is_resend,
                           q_data.tx_valid};
    assign m_axis_tlast = q_data.last;

endmodule

FILE: design/gbnsw_chk.sv
// Checker: port-level assertions on the sender window, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gbnsw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // empty output after a reset cycle
    `A_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid)

    // hold a stalled result
    `A_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // only a resend run has results before its last one
    `A_IMPLY(a_mid_resend, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tuser[0] && m_axis_tuser[1])

    // an accepted send transmits fresh and leaves the window nonempty
    `A_IMPLY(a_acc_send, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[0] && !m_axis_tuser[1] && m_axis_tdata[28:24] != 5'd0)

endmodule

bind gbn_sender_window_top gbnsw_chk u_gbnsw_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
